@@ rtl/core/uml_pkg.sv @@
// Shared types and constants for the UART memory loader bridge.
// No dependencies; imported by every module in rtl/core.
package uml_pkg;

    // Command characters
    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChRead    = 8'h52;  // 'R'
    localparam logic [7:0] ChWrite   = 8'h57;  // 'W'
    localparam logic [7:0] ChBoot    = 8'h42;  // 'B'

    localparam logic [31:0] BootAddrReset = 32'h7fff_fffc;

    // Depth of the job queue between front and back
    localparam int QDepth = 4;

    // Beat on which a read-return job issues its follow-up read request
    localparam logic [2:0] RdReqBeat = 3'd4;

    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        J_ECHO  = 3'd0,   // echo newline
        J_BOOT  = 3'd1,   // boot switch write
        J_RREQ  = 3'd2,   // first read request of a command
        J_WRITE = 3'd3,   // bus write of an assembled word
        J_RDATA = 3'd4    // four tx bytes, then maybe the next read request
    } t_jtype;

    typedef struct packed {
        t_jtype      jtype;
        logic [31:0] addr;
        logic [31:0] data;
        logic        more;   // read return: another read follows
    } t_job;

endpackage

@@ rtl/core/uart_memory_loader_bridge.sv @@
// UART memory loader bridge, top level: APB register, front parser, job queue, back part.
// Depends on uml_pkg, uml_front, uml_queue, uml_back.
//
// The bridge takes one request per cycle: a received UART byte or a memory read return.
// The front parser runs the command protocol ('\n' echo, 'R'/'W' with big-endian
// address and count, 'B' boot write then halt) and turns each request into at most
// one job, pushed into a QDepth-entry queue. The back part emits one result per
// cycle while i_ready lets it, from the job at the queue head: a read return
// yields four transmit bytes (MSB first) plus the next read request when words
// remain, and every other job yields a single result. Requests that make no
// result (address/count bytes, ignored bytes) push no job, but like every
// request they wait while the queue is full.
// i_ready low stalls only the back part; o_ready drops only when the queue is full.
// boot_switch_addr lives at byte address 0 of the APB port (reset 0x7ffffffc)
// and should be written only while the bridge is idle. No startup greeting is sent.
module uart_memory_loader_bridge #(
    parameter int QDepth = uml_pkg::QDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_read_data,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_tx_byte,
    output logic [31:0] o_bus_addr,
    output logic [31:0] o_bus_wdata,
    output logic        o_last,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uml_pkg::*;

    localparam logic RegIdxBoot = 1'b0;   // word index of boot_switch_addr

    logic [31:0] r_boot_addr;
    logic        cfg_wr;

    logic        q_full, q_valid, q_push, q_pop;
    t_job        push_job, head_job;

    // APB: zero-wait, word index in paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegIdxBoot);
    assign prdata = (paddr[2] == RegIdxBoot) ? r_boot_addr : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_addr <= BootAddrReset;
        end else if (cfg_wr) begin
            r_boot_addr <= pwdata;
        end
    end

    // front: parse requests into jobs
    uml_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_rx_byte   (i_rx_byte),
        .i_read_data (i_read_data),
        .i_boot_addr (r_boot_addr),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    // decoupling queue
    uml_queue #(
        .Depth (QDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // back: one result per cycle into the output register, unless i_ready stalls it
    uml_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_kind  (o_out_kind),
        .o_tx_byte   (o_tx_byte),
        .o_bus_addr  (o_bus_addr),
        .o_bus_wdata (o_bus_wdata),
        .o_last      (o_last)
    );

endmodule

@@ rtl/core/uml_front.sv @@
// Front part: accepts input items, runs the command parser, pushes jobs.
// Depends on uml_pkg.
module uml_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_req_type,
    input  logic [7:0]        i_rx_byte,
    input  logic [31:0]       i_read_data,
    input  logic [31:0]       i_boot_addr,
    input  logic              i_q_full,
    output logic              o_push,
    output uml_pkg::t_job     o_job
);
    import uml_pkg::*;

    typedef enum logic [2:0] {
        PH_CMD, PH_ADDR, PH_COUNT, PH_DATA, PH_RWAIT, PH_HALT
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_is_write, n_is_write;
    logic [1:0]  r_idx, n_idx;
    logic [31:0] r_asm, n_asm;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_left, n_left;

    logic        accept;
    logic        done;
    logic [31:0] packed_word;
    logic [31:0] addr_p4;
    logic [31:0] left_m1;

    assign o_ready     = !i_q_full;
    assign accept      = i_valid && !i_q_full;
    assign packed_word = {r_asm[23:0], i_rx_byte};
    assign done        = (r_idx == 2'd3);
    assign addr_p4     = r_addr + 32'd4;
    assign left_m1     = r_left - 32'd1;

    always_comb begin
        n_phase    = r_phase;
        n_is_write = r_is_write;
        n_idx      = r_idx;
        n_asm      = r_asm;
        n_addr     = r_addr;
        n_left     = r_left;
        o_push     = 1'b0;
        o_job      = '{jtype: J_ECHO, addr: '0, data: '0, more: 1'b0};

        if (accept) begin
            if (i_req_type) begin
                // read return; ignored unless a read is pending
                if (r_phase == PH_RWAIT) begin
                    o_push     = 1'b1;
                    o_job      = '{jtype: J_RDATA, addr: addr_p4, data: i_read_data,
                                   more: (left_m1 != 32'd0)};
                    n_addr     = addr_p4;
                    n_left     = left_m1;
                    if (left_m1 == 32'd0) begin
                        n_phase = PH_CMD;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_CMD: begin
                        if (i_rx_byte == ChNewline) begin
                            o_push = 1'b1;
                            o_job  = '{jtype: J_ECHO, addr: '0, data: '0, more: 1'b0};
                        end else if (i_rx_byte == ChRead || i_rx_byte == ChWrite) begin
                            n_is_write = (i_rx_byte == ChWrite);
                            n_idx      = 2'd0;
                            n_asm      = '0;
                            n_phase    = PH_ADDR;
                        end else if (i_rx_byte == ChBoot) begin
                            o_push  = 1'b1;
                            o_job   = '{jtype: J_BOOT, addr: i_boot_addr, data: 32'd1,
                                        more: 1'b0};
                            n_phase = PH_HALT;
                        end
                    end
                    PH_ADDR: begin
                        n_asm = packed_word;
                        n_idx = r_idx + 2'd1;
                        if (done) begin
                            n_addr  = packed_word;
                            n_asm   = '0;
                            n_phase = PH_COUNT;
                        end
                    end
                    PH_COUNT: begin
                        n_asm = packed_word;
                        n_idx = r_idx + 2'd1;
                        if (done) begin
                            n_left = packed_word;
                            n_asm  = '0;
                            if (packed_word == 32'd0) begin
                                n_phase = PH_CMD;
                            end else if (r_is_write) begin
                                n_phase = PH_DATA;
                            end else begin
                                o_push  = 1'b1;
                                o_job   = '{jtype: J_RREQ, addr: r_addr, data: '0,
                                            more: 1'b0};
                                n_phase = PH_RWAIT;
                            end
                        end
                    end
                    PH_DATA: begin
                        n_asm = packed_word;
                        n_idx = r_idx + 2'd1;
                        if (done) begin
                            o_push = 1'b1;
                            o_job  = '{jtype: J_WRITE, addr: r_addr, data: packed_word,
                                       more: 1'b0};
                            n_asm  = '0;
                            n_addr = addr_p4;
                            n_left = left_m1;
                            if (left_m1 == 32'd0) begin
                                n_phase = PH_CMD;
                            end
                        end
                    end
                    PH_RWAIT, PH_HALT: begin
                        // bytes dropped while a read is pending or after boot
                    end
                    default: begin
                        n_phase = PH_CMD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CMD;
            r_is_write <= 1'b0;
            r_idx      <= 2'd0;
            r_asm      <= '0;
            r_addr     <= '0;
            r_left     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_is_write <= n_is_write;
            r_idx      <= n_idx;
            r_asm      <= n_asm;
            r_addr     <= n_addr;
            r_left     <= n_left;
        end
    end

endmodule

@@ rtl/core/uml_queue.sv @@
// Job queue between front and back parts, a small register FIFO.
// Depends on uml_pkg.
module uml_queue #(
    parameter int Depth = uml_pkg::QDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  uml_pkg::t_job     i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output uml_pkg::t_job     o_job
);
    import uml_pkg::*;

    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int Cw = $clog2(Depth + 1);
    localparam logic [Aw-1:0] LastIdx = Aw'(Depth - 1);
    localparam logic [Cw-1:0] Full    = Cw'(Depth);

    t_job          r_mem [Depth];
    logic [Aw-1:0] r_wr_ptr, r_rd_ptr;
    logic [Cw-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == Full);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastIdx) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastIdx) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/uml_back.sv @@
// Back part: expands queued jobs into result items, one per cycle when not stalled.
// Depends on uml_pkg.
module uml_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  uml_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_out_kind,
    output logic [7:0]        o_tx_byte,
    output logic [31:0]       o_bus_addr,
    output logic [31:0]       o_bus_wdata,
    output logic              o_last
);
    import uml_pkg::*;

    logic [2:0]  r_beat;
    logic        r_valid;
    t_kind       r_kind;
    logic [7:0]  r_tx;
    logic [31:0] r_addr, r_wdata;
    logic        r_last;

    logic        load;
    t_kind       res_kind;
    logic [7:0]  res_tx;
    logic [31:0] res_addr, res_wdata;
    logic        res_last;
    logic [7:0]  sel_byte;

    assign load  = i_q_valid && (!r_valid || i_ready);
    assign o_pop = load && res_last;

    always_comb begin
        case (r_beat[1:0])
            2'd0:    sel_byte = i_job.data[31:24];
            2'd1:    sel_byte = i_job.data[23:16];
            2'd2:    sel_byte = i_job.data[15:8];
            default: sel_byte = i_job.data[7:0];
        endcase
    end

    always_comb begin
        res_kind  = KIND_TX;
        res_tx    = '0;
        res_addr  = '0;
        res_wdata = '0;
        res_last  = 1'b1;
        unique case (i_job.jtype)
            J_ECHO: begin
                res_tx = ChNewline;
            end
            J_BOOT, J_WRITE: begin
                res_kind  = KIND_WRITE;
                res_addr  = i_job.addr;
                res_wdata = i_job.data;
            end
            J_RREQ: begin
                res_kind = KIND_READ;
                res_addr = i_job.addr;
            end
            J_RDATA: begin
                if (r_beat == RdReqBeat) begin
                    res_kind = KIND_READ;
                    res_addr = i_job.addr;
                end else begin
                    res_tx   = sel_byte;
                    res_last = (r_beat == 3'd3) && !i_job.more;
                end
            end
            default: begin
                res_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= res_kind;
            r_tx    <= res_tx;
            r_addr  <= res_addr;
            r_wdata <= res_wdata;
            r_last  <= res_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_beat  <= res_last ? 3'd0 : r_beat + 3'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_out_kind  = r_kind;
    assign o_tx_byte   = r_tx;
    assign o_bus_addr  = r_addr;
    assign o_bus_wdata = r_wdata;
    assign o_last      = r_last;

endmodule

@@ rtl/core/uml_checker.sv @@
// Port-level checker for the loader bridge, bound to the top level.
// Depends on uml_pkg and uart_memory_loader_bridge top-level ports.
module uml_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [1:0]  o_out_kind,
    input  logic [7:0]  o_tx_byte,
    input  logic [31:0] o_bus_addr,
    input  logic [31:0] o_bus_wdata,
    input  logic        o_last
);
    import uml_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_kind) && $stable(o_tx_byte)
            && $stable(o_bus_addr) && $stable(o_bus_wdata) && $stable(o_last))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_kind == KIND_TX || o_out_kind == KIND_READ
            || o_out_kind == KIND_WRITE)
        else $error("undefined result kind");

    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind == KIND_TX |-> o_bus_addr == '0 && o_bus_wdata == '0)
        else $error("transmit carries bus fields");

    a_rd_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind == KIND_READ |-> o_tx_byte == '0 && o_bus_wdata == '0
            && o_last)
        else $error("read request malformed");

endmodule

bind uart_memory_loader_bridge uml_checker u_uml_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_kind  (o_out_kind),
    .o_tx_byte   (o_tx_byte),
    .o_bus_addr  (o_bus_addr),
    .o_bus_wdata (o_bus_wdata),
    .o_last      (o_last)
);

@@ sim/tb_uart_memory_loader_bridge.sv @@
// Self-checking testbench for uart_memory_loader_bridge: directed table, then random requests
// checked against a built-in predictor of the command parser. Depends on uml_pkg and the RTL.
module tb_uart_memory_loader_bridge;
    import uml_pkg::*;

    localparam int QuietLimit   = 2000;  // cycles with no handshake at all before giving up
    localparam int SettleCycles = 40;    // settle time after the expected results are out, with slack
    localparam int HoldCycles   = 300;   // long receiver hold-off, fills the job queue
    localparam int PhaseRequests = 95;   // requests per random phase that do real work

    localparam logic [2:0] BootAddrReg = 3'd0;  // byte address of boot_switch_addr

    // parser position, mirrors the command protocol
    typedef enum logic [2:0] {
        AWAIT_CMD, TAKE_ADDR, TAKE_COUNT, TAKE_DATA, READ_WAIT, HALTED
    } t_parse;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic        last;
    } t_bus_result;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  rx;
        logic [31:0] rdata;
        logic        typed;   // want holds the single expected result
        t_bus_result want;
    } t_stim_row;

    localparam t_bus_result Untyped = '{KIND_TX, 8'h00, 32'h0, 32'h0, 1'b0};

    // Directed requests. Typed results: newline echo, first read request at the top
    // address, and a single-word write. Read returns go through the predictor.
    localparam t_stim_row Directed [29] = '{
        '{1'b0, ChNewline, 32'hFFFF_FFFF, 1'b1, '{KIND_TX, ChNewline, 32'h0, 32'h0, 1'b1}},
        '{1'b0, 8'hFF, 32'h0, 1'b0, Untyped},          // unknown command bytes
        '{1'b0, 8'h00, 32'h0, 1'b0, Untyped},
        '{1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b0, Untyped},  // read data with no read pending
        '{1'b0, ChRead, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'hFF, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'hFF, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'hFF, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'hFC, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h00, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h00, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h00, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h02, 32'h0, 1'b1, '{KIND_READ, 8'h00, 32'hFFFF_FFFC, 32'h0, 1'b1}},
        '{1'b0, ChBoot, 32'h0, 1'b0, Untyped},         // dropped, a read is pending
        '{1'b1, 8'h00, 32'hFFFF_FFFF, 1'b0, Untyped},  // next read wraps to 0
        '{1'b1, 8'hFF, 32'h0000_0000, 1'b0, Untyped},
        '{1'b0, ChWrite, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h00, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h00, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h00, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h00, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h00, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h00, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h00, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h01, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h80, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h7F, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'h01, 32'h0, 1'b0, Untyped},
        '{1'b0, 8'hFE, 32'hFFFF_FFFF, 1'b1, '{KIND_WRITE, 8'h00, 32'h0, 32'h807F_01FE, 1'b1}}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic        i_req_type  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic [31:0] i_read_data = 32'h0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [1:0]  o_out_kind;
    logic [7:0]  o_tx_byte;
    logic [31:0] o_bus_addr;
    logic [31:0] o_bus_wdata;
    logic        o_last;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = 3'd0;
    logic [31:0] pwdata      = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // typed expectation travels with the request payload
    logic        typed_on    = 1'b0;
    t_bus_result typed_want  = Untyped;

    // predictor state and its copy of the register
    t_parse      m_phase;
    logic        m_is_write;
    logic [1:0]  m_byte_idx;
    logic [31:0] m_word;
    logic [31:0] m_addr;
    logic [31:0] m_left;
    logic [31:0] m_boot_addr;

    t_bus_result step_res [5];
    int          step_n;
    bit          step_took;

    t_bus_result pending_outputs [$];
    t_bus_result oldest;
    int          requests_taken  = 0;
    int          useful_requests = 0;
    int          results_seen    = 0;
    int          mismatch_count  = 0;
    int          quiet_cycles    = 0;
    int          send_idle_pct   = 0;
    int          recv_idle_pct   = 0;
    int          hold_calls      = 0;
    int          hold_served     = 0;
    int          hold_left       = 0;
    int          k;

    uart_memory_loader_bridge DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_rx_byte   (i_rx_byte),
        .i_read_data (i_read_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_kind  (o_out_kind),
        .o_tx_byte   (o_tx_byte),
        .o_bus_addr  (o_bus_addr),
        .o_bus_wdata (o_bus_wdata),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s at result %0d: got %h, expected %h",
                 what, results_seen, got, want);
        mismatch_count++;
    endtask

    function automatic void reset_bridge_model();
        m_phase     = AWAIT_CMD;
        m_is_write  = 1'b0;
        m_byte_idx  = 2'd0;
        m_word      = 32'h0;
        m_addr      = 32'h0;
        m_left      = 32'h0;
        m_boot_addr = BootAddrReset;
    endfunction

    function automatic void add_result(t_kind kind, logic [7:0] b, logic [31:0] a,
                                       logic [31:0] d);
        step_res[step_n] = '{kind, b, a, d, 1'b0};
        step_n++;
    endfunction

    // big-endian byte assembly; true once the fourth byte is in
    function automatic bit shift_in(logic [7:0] b);
        m_word     = {m_word[23:0], b};
        m_byte_idx = m_byte_idx + 2'd1;
        return m_byte_idx == 2'd0;
    endfunction

    // Advances the predicted parser by one request; results land in step_res.
    function automatic void predict_bridge_step(logic kind, logic [7:0] b, logic [31:0] rd);
        int i;
        step_n    = 0;
        step_took = 1'b0;
        if (kind) begin
            if (m_phase == READ_WAIT) begin
                step_took = 1'b1;
                for (i = 0; i < 4; i++) begin
                    add_result(KIND_TX, 8'(rd >> (24 - 8 * i)), 32'h0, 32'h0);
                end
                m_addr = m_addr + 32'd4;
                m_left = m_left - 32'd1;
                if (m_left != 0) add_result(KIND_READ, 8'h00, m_addr, 32'h0);
                else m_phase = AWAIT_CMD;
            end
        end else begin
            case (m_phase)
                AWAIT_CMD: begin
                    if (b == ChNewline) begin
                        step_took = 1'b1;
                        add_result(KIND_TX, ChNewline, 32'h0, 32'h0);
                    end else if (b == ChRead || b == ChWrite) begin
                        step_took  = 1'b1;
                        m_is_write = (b == ChWrite);
                        m_byte_idx = 2'd0;
                        m_word     = 32'h0;
                        m_phase    = TAKE_ADDR;
                    end else if (b == ChBoot) begin
                        step_took = 1'b1;
                        add_result(KIND_WRITE, 8'h00, m_boot_addr, 32'h1);
                        m_phase = HALTED;
                    end
                end
                TAKE_ADDR: begin
                    step_took = 1'b1;
                    if (shift_in(b)) begin
                        m_addr  = m_word;
                        m_word  = 32'h0;
                        m_phase = TAKE_COUNT;
                    end
                end
                TAKE_COUNT: begin
                    step_took = 1'b1;
                    if (shift_in(b)) begin
                        m_left = m_word;
                        m_word = 32'h0;
                        if (m_left == 0) begin
                            m_phase = AWAIT_CMD;
                        end else if (m_is_write) begin
                            m_phase = TAKE_DATA;
                        end else begin
                            add_result(KIND_READ, 8'h00, m_addr, 32'h0);
                            m_phase = READ_WAIT;
                        end
                    end
                end
                TAKE_DATA: begin
                    step_took = 1'b1;
                    if (shift_in(b)) begin
                        add_result(KIND_WRITE, 8'h00, m_addr, m_word);
                        m_word = 32'h0;
                        m_addr = m_addr + 32'd4;
                        m_left = m_left - 32'd1;
                        if (m_left == 0) m_phase = AWAIT_CMD;
                    end
                end
                default: ;  // read pending drops the byte, halted ignores it
            endcase
        end
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
    endfunction

    // Request and result handshakes, in a fixed order within the edge.
    always @(posedge i_clk) begin
        if (i_valid && o_ready === 1'b1) begin
            predict_bridge_step(i_req_type, i_rx_byte, i_read_data);
            if (step_took) useful_requests++;
            if (typed_on) begin
                pending_outputs.push_back(typed_want);
            end else begin
                for (k = 0; k < step_n; k++) pending_outputs.push_back(step_res[k]);
            end
            requests_taken++;
        end
        if (o_valid === 1'b1 && i_ready) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch("unexpected result, kind", 32'(o_out_kind), 32'h0);
            end else begin
                oldest = pending_outputs.pop_front();
                if (o_out_kind !== oldest.kind)
                    report_mismatch("out_kind", 32'(o_out_kind), 32'(oldest.kind));
                if (o_tx_byte !== oldest.tx)
                    report_mismatch("tx_byte", 32'(o_tx_byte), 32'(oldest.tx));
                if (o_bus_addr !== oldest.addr)
                    report_mismatch("bus_addr", o_bus_addr, oldest.addr);
                if (o_bus_wdata !== oldest.wdata)
                    report_mismatch("bus_wdata", o_bus_wdata, oldest.wdata);
                if (o_last !== oldest.last)
                    report_mismatch("last", 32'(o_last), 32'(oldest.last));
            end
            results_seen++;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
    always @(posedge i_clk) begin
        if (hold_calls != hold_served) begin
            hold_served = hold_calls;
            hold_left   = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a stretch with no handshake on either side ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QuietLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offers one request and returns at the edge that accepts it.
    task automatic send_request(input logic kind, input logic [7:0] b, input logic [31:0] rd,
                                input logic typed, input t_bus_result want);
        int ticket;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        ticket = requests_taken + 1;
        i_valid     <= 1'b1;
        i_req_type  <= kind;
        i_rx_byte   <= b;
        i_read_data <= rd;
        typed_on    <= typed;
        typed_want  <= want;
        wait (requests_taken == ticket);
    endtask

    // Mostly well-formed commands with random content, steered by the predicted
    // parser position; some stray read data, dropped bytes and junk in between.
    task automatic send_random_request();
        logic [7:0]  b;
        logic [31:0] rd;
        logic        kind;
        int          pick;
        b    = 8'($urandom);
        rd   = $urandom;
        kind = 1'b0;
        pick = $urandom_range(99);
        case (m_phase)
            AWAIT_CMD: begin
                if (pick < 35) b = ChRead;
                else if (pick < 70) b = ChWrite;
                else if (pick < 80) b = ChNewline;
                else if (pick < 90) begin
                    while (b == ChBoot) b = 8'($urandom);
                end else kind = 1'b1;
            end
            TAKE_ADDR: begin
                if (pick < 5) kind = 1'b1;
                else if (pick < 35) b = (m_byte_idx == 2'd3) ? 8'hFC : 8'hFF;
                else if (pick < 45) b = 8'h00;
            end
            TAKE_COUNT: begin
                if (pick < 5) kind = 1'b1;
                else b = (m_byte_idx == 2'd3) ? 8'($urandom_range(4)) : 8'h00;
            end
            TAKE_DATA: begin
                if (pick < 5) kind = 1'b1;
            end
            default: begin
                // read pending: mostly the return, sometimes a byte that gets dropped
                if (pick >= 10) begin
                    kind = 1'b1;
                    if (pick < 20) rd = 32'hFFFF_FFFF;
                    else if (pick < 30) rd = 32'h0;
                end
            end
        endcase
        send_request(kind, b, rd, 1'b0, Untyped);
    endtask

    // Waits until every expected result is out, then lets the last jobs settle.
    task automatic drain_outputs();
        i_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] a, output logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        d = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes the boot address, reads it back, and updates the predictor's copy.
    task automatic set_boot_addr(input logic [31:0] value);
        logic [31:0] readback;
        apb_write(BootAddrReg, value);
        apb_read(BootAddrReg, readback);
        if (readback !== value) report_mismatch("boot_switch_addr readback", readback, value);
        m_boot_addr = value;
    endtask

    initial begin
        logic [31:0] readback;
        int          mark;
        int          p;
        int          r;
        reset_bridge_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apb_read(BootAddrReg, readback);
        if (readback !== BootAddrReset)
            report_mismatch("boot_switch_addr after reset", readback, BootAddrReset);
        set_boot_addr(32'h0);

        send_idle_pct = 8;
        recv_idle_pct = 46;
        for (r = 0; r < 29; r++) begin
            send_request(Directed[r].req_type, Directed[r].rx, Directed[r].rdata,
                         Directed[r].typed, Directed[r].want);
        end

        // three random phases: sender idles lightly, then the receiver does, then nobody
        for (p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 8;
                    recv_idle_pct = 46;
                    hold_calls++;   // long receiver hold-off: queue fills, input stalls
                end
                1: begin
                    send_idle_pct = 46;
                    recv_idle_pct = 8;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            mark = useful_requests;
            while (useful_requests - mark < PhaseRequests) send_random_request();
            drain_outputs();
            case (p)
                0: set_boot_addr(32'hFFFF_FFFF);
                1: set_boot_addr($urandom);
                default: set_boot_addr(32'h0);
            endcase
        end

        // finish any open command, boot, then check that the bridge stays halted
        while (m_phase != AWAIT_CMD) send_random_request();
        send_request(1'b0, ChBoot, $urandom, 1'b1,
                     '{KIND_WRITE, 8'h00, m_boot_addr, 32'h1, 1'b1});
        send_request(1'b0, ChNewline, $urandom, 1'b0, Untyped);
        send_request(1'b0, ChRead, $urandom, 1'b0, Untyped);
        send_request(1'b1, 8'($urandom), 32'hA5A5_5A5A, 1'b0, Untyped);
        drain_outputs();

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ uart_memory_loader_bridge.f @@
rtl/core/uml_pkg.sv
rtl/core/uml_front.sv
rtl/core/uml_queue.sv
rtl/core/uml_back.sv
rtl/core/uml_checker.sv
rtl/core/uart_memory_loader_bridge.sv
sim/tb_uart_memory_loader_bridge.sv
